// File: src/gbn_pkg.sv
// Package for the go-back-N sender window core: event codes, register
// indexes, reset values and the result record. No dependencies.
package gbn_pkg;

   localparam int unsigned PACKET_BYTES_DEFAULT = 1024;

   localparam int unsigned WINDOW_W  = 16;
   localparam int unsigned FILE_W    = 32;
   localparam int unsigned TIMEOUT_W = 8;
   localparam int unsigned CSR_W     = 32;
   localparam int unsigned INDEX_W   = 33;
   localparam int unsigned TICK_W    = 9;
   localparam int unsigned LEN_OUT_W = 11;

   localparam logic [WINDOW_W-1:0]  WINDOW_SIZE_RESET = 16'd4;
   localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET     = 8'd5;
   localparam logic [TICK_W-1:0]    TICK_MAX          = 9'd511;

   typedef enum logic [1:0] {
      FUNC_SEND = 2'd0,
      FUNC_ACK  = 2'd1,
      FUNC_TICK = 2'd2,
      FUNC_FIN  = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      CSR_WINDOW_SIZE   = 2'd0,
      CSR_FILE_BYTES    = 2'd1,
      CSR_TIMEOUT_TICKS = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic                 send_valid;
      logic [FILE_W-1:0]    seq_number;
      logic [LEN_OUT_W-1:0] payload_len;
      logic                 slid;
      logic                 rewound;
      logic                 done_res;
   } result_type;

endpackage

// File: src/gbn_window.sv
// Window state and event logic of the go-back-N sender: holds the configuration
// and counters, and works out one event per step_en cycle. Uses gbn_pkg.
module gbn_window import gbn_pkg::*; #(
   parameter int unsigned PACKET_BYTES = PACKET_BYTES_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_we,
   input  logic [1:0]        csr_index,
   input  logic [CSR_W-1:0]  csr_wdata,
   input  logic              step_en,
   input  func_type          func,
   input  logic [FILE_W-1:0] ack_number,
   output result_type        result
);

   localparam int unsigned LOG   = $clog2(PACKET_BYTES);
   localparam int unsigned LEN_W = LOG + 1;
   localparam int unsigned OFF_W = INDEX_W + LOG;

   logic [WINDOW_W-1:0]  window_size_ff,  window_size_in;
   logic [FILE_W-1:0]    file_bytes_ff,   file_bytes_in;
   logic [TIMEOUT_W-1:0] timeout_ff,      timeout_in;
   logic [FILE_W-1:0]    next_pos_ff,     next_pos_in;
   logic [FILE_W-1:0]    next_off_ff,     next_off_in;
   logic [INDEX_W-1:0]   win_end_ff,      win_end_in;
   logic [TICK_W-1:0]    tick_ff,         tick_in;
   logic                 finished_ff,     finished_in;

   logic [INDEX_W-1:0] base;
   logic               done_now;
   logic [FILE_W-1:0]  remain;
   logic [LEN_W-1:0]   len;
   logic [INDEX_W-1:0] ack_q;
   logic [INDEX_W-1:0] ack_idx;
   logic [INDEX_W-1:0] npk;
   logic [TICK_W-1:0]  tick_inc;
   logic [OFF_W-1:0]   off_wide;
   logic [FILE_W-1:0]  off_sat;

   always_comb begin
      base     = win_end_ff - INDEX_W'(window_size_ff);
      done_now = finished_ff || (file_bytes_ff == '0);
      remain   = file_bytes_ff - next_off_ff;
      if (next_off_ff >= file_bytes_ff) begin
         len = '0;
      end else if (remain > FILE_W'(PACKET_BYTES)) begin
         len = LEN_W'(PACKET_BYTES);
      end else begin
         len = remain[LEN_W-1:0];
      end
      // ceil(ack / packet) by shift
      ack_q    = ({1'b0, ack_number} + INDEX_W'(PACKET_BYTES - 1)) >> LOG;
      ack_idx  = ack_q - INDEX_W'(1);
      npk      = ({1'b0, file_bytes_ff} + INDEX_W'(PACKET_BYTES - 1)) >> LOG;
      tick_inc = (tick_ff == TICK_MAX) ? tick_ff : tick_ff + TICK_W'(1);
      off_wide = OFF_W'(base) << LOG;
      off_sat  = (off_wide[OFF_W-1:FILE_W] != '0) ? '1 : off_wide[FILE_W-1:0];
   end

   always_comb begin
      window_size_in = window_size_ff;
      file_bytes_in  = file_bytes_ff;
      timeout_in     = timeout_ff;
      next_pos_in    = next_pos_ff;
      next_off_in    = next_off_ff;
      win_end_in     = win_end_ff;
      tick_in        = tick_ff;
      finished_in    = finished_ff;
      result         = '0;

      if (csr_we) begin
         priority case (csr_index)
            CSR_WINDOW_SIZE: begin
               // keep the base, move the end
               window_size_in = csr_wdata[WINDOW_W-1:0];
               win_end_in     = base + INDEX_W'(csr_wdata[WINDOW_W-1:0]);
            end
            CSR_FILE_BYTES:    file_bytes_in = csr_wdata[FILE_W-1:0];
            CSR_TIMEOUT_TICKS: timeout_in    = csr_wdata[TIMEOUT_W-1:0];
            default: ;
         endcase
      end else if (step_en && !done_now) begin
         unique case (func)
            FUNC_SEND: begin
               if ({1'b0, next_pos_ff} < win_end_ff) begin
                  result.send_valid  = 1'b1;
                  result.seq_number  = next_off_ff;
                  result.payload_len = LEN_OUT_W'(len);
                  next_pos_in        = next_pos_ff + FILE_W'(1);
                  next_off_in        = next_off_ff + FILE_W'(len);
               end
            end
            FUNC_ACK: begin
               tick_in = '0;
               if (ack_q != '0 && ack_idx >= base) begin
                  win_end_in  = ack_idx + INDEX_W'(1) + INDEX_W'(window_size_ff);
                  result.slid = 1'b1;
                  if (npk != '0 && ack_idx >= npk - INDEX_W'(1)) begin
                     finished_in = 1'b1;
                  end
               end
            end
            FUNC_TICK: begin
               tick_in = tick_inc;
               if (tick_inc > TICK_W'(timeout_ff)) begin
                  // rewind to the window base
                  next_pos_in    = base[FILE_W-1:0];
                  next_off_in    = off_sat;
                  tick_in        = '0;
                  result.rewound = 1'b1;
               end
            end
            FUNC_FIN: finished_in = 1'b1;
         endcase
      end
      result.done_res = finished_in || (file_bytes_in == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_size_ff <= WINDOW_SIZE_RESET;
         file_bytes_ff  <= '0;
         timeout_ff     <= TIMEOUT_RESET;
         next_pos_ff    <= '0;
         next_off_ff    <= '0;
         win_end_ff     <= INDEX_W'(WINDOW_SIZE_RESET);
         tick_ff        <= '0;
         finished_ff    <= 1'b0;
      end else begin
         window_size_ff <= window_size_in;
         file_bytes_ff  <= file_bytes_in;
         timeout_ff     <= timeout_in;
         next_pos_ff    <= next_pos_in;
         next_off_ff    <= next_off_in;
         win_end_ff     <= win_end_in;
         tick_ff        <= tick_in;
         finished_ff    <= finished_in;
      end
   end

endmodule

// File: src/go_back_n_sender_window_core.sv
// Go-back-N sender window core. Each request beat is an event (send slot, ack,
// tick or peer fin) and yields exactly one response beat: a packet descriptor
// and the slid, rewound and done flags. One event per clock is sustained while
// the response is not stalled; an accepted event is held in the input register
// while the window logic works it out; the state update and response register
// load share the edge that moves it on, so the response beat is offered from
// the response register. A stalled response holds the input register and drops
// req_tready once that register is full. Write csr_ registers only while no
// event is in flight. PACKET_BYTES must be a power of two.
module go_back_n_sender_window_core import gbn_pkg::*; #(
   parameter int unsigned PACKET_BYTES = PACKET_BYTES_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   // request channel
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [31:0]       req_tdata,  // [31:0] ack_number
   input  logic [1:0]        req_tuser,  // [1:0] func
   // response channel
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [47:0]       rsp_tdata,  // [0] send_valid, [32:1] seq_number,
                                         // [43:33] payload length, [44] slid,
                                         // [45] rewound, [46] done_res
   // configuration
   input  logic              csr_we,
   input  logic [1:0]        csr_index,
   input  logic [CSR_W-1:0]  csr_wdata
);

   logic              in_valid_ff, in_valid_in;
   logic [1:0]        in_func_ff;
   logic [FILE_W-1:0] in_ack_ff;
   logic              out_valid_ff, out_valid_in;
   result_type        out_ff;
   result_type        result;
   logic              advance;

   // advance the input beat when the response register is free or draining
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in  = req_tready ? req_tvalid : in_valid_ff;
      out_valid_in = advance ? 1'b1 : (out_valid_ff && !rsp_tready);
   end

   gbn_window #(
      .PACKET_BYTES (PACKET_BYTES)
   ) u_window (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .step_en    (advance),
      .func       (func_type'(in_func_ff)),
      .ack_number (in_ack_ff),
      .result     (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_func_ff <= req_tuser;
         in_ack_ff  <= req_tdata;
      end
      if (advance) begin
         out_ff <= result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {1'b0, out_ff.done_res, out_ff.rewound, out_ff.slid,
                        out_ff.payload_len, out_ff.seq_number, out_ff.send_valid};

endmodule
